// ===== src/kwg_pkg.sv =====
// ----------------------------------------------------------------------------
// kwg_pkg
// Shared types and constants of the Kaiser window generator: the internal
// number format, the datapath operation codes and the command/status words.
// ----------------------------------------------------------------------------
package kwg_pkg;

    // value = m * 2^e, m is zero or lies in [2^31, 2^32)
    typedef struct packed {
        logic [31:0]        m;
        logic signed [15:0] e;
    } t_xn;

    localparam t_xn XN_ZERO = '{m: 32'd0,          e: 16'sd0};
    localparam t_xn XN_ONE  = '{m: 32'h8000_0000,  e: -16'sd31};
    localparam t_xn XN_PI   = '{m: 32'd3373259426, e: -16'sd30};
    localparam t_xn XN_EPS  = '{m: 32'd2361183241, e: -16'sd71};

    localparam logic [18:0] ONE_Q18 = 19'd262144;

    localparam logic CFG_LENGTH = 1'b0;
    localparam logic CFG_BETA   = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,    // beta to internal form, m*(M-1-m)
        OP_NUMC,    // numc = pi * beta
        OP_SQRT,    // root of the shifted product
        OP_ZDIV,    // tmp = tmp / (M-1)
        OP_ZMUL,    // z = numc * tmp
        OP_SQ,      // t = arg^2 / 4
        OP_BINIT,   // sum = 1 + t, term = t
        OP_TDIV,    // tmp = t / k^2
        OP_TMUL,    // term = term * tmp
        OP_SADD,    // sum = sum + term
        OP_EMUL,    // tmp = eps * sum
        OP_SAVE,    // num = sum
        OP_QDIV,    // mantissa ratio
        OP_FIN      // round, saturate, emit
    } t_op;

    typedef struct packed {
        logic load;
        logic go;
        t_op  op;
        logic pass;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic oor;
        logic centre;
        logic q_zero;
        logic lt;
        logic k_last;
    } t_st;

endpackage

// ===== src/kaiser_window_generator.sv =====
// ----------------------------------------------------------------------------
// kaiser_window_generator
// Kaiser window weight I0(pi*beta*sqrt(1-p^2))/I0(pi*beta) per sample position.
// ----------------------------------------------------------------------------
// One position is taken at a time: start is accepted while busy is low and
// the weight comes back on a one-cycle o_result_strobe some time later; the
// receiver cannot stall it. Positions out of range and the window centre go
// from the check state straight to the final state. Other positions are
// paced by the bit-serial divider (one quotient bit per cycle) that every
// divided series term passes through, two series per word, each with up
// to MAX_TERMS-2 divided terms; a zero argument or a small beta
// ends a series after one term. Configuration writes are always accepted and
// must only be made while busy is low.
module kaiser_window_generator import kwg_pkg::*; #(
    parameter int MAX_LENGTH = 4096,
    parameter int MAX_TERMS  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_position,
    output logic        o_result_strobe,
    output logic [11:0] o_position_echo,
    output logic [18:0] o_weight,
    output logic        o_out_of_range,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd cmd;
    t_st  st;

    assign o_cfg_ready = 1'b1;

    kwg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    kwg_datapath #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_TERMS  (MAX_TERMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_position      (i_position),
        .i_cmd           (cmd),
        .o_st            (st),
        .o_result_strobe (o_result_strobe),
        .o_position_echo (o_position_echo),
        .o_weight        (o_weight),
        .o_out_of_range  (o_out_of_range)
    );

endmodule

// ===== src/kwg_datapath.sv =====
// ----------------------------------------------------------------------------
// kwg_datapath
// Configuration registers and the shared arithmetic: a two-stage multiplier,
// an adder, a bit-serial divider and a bit-serial square root.
// ----------------------------------------------------------------------------
module kwg_datapath import kwg_pkg::*; #(
    parameter int MAX_LENGTH = 4096,
    parameter int MAX_TERMS  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [11:0] i_position,
    input  t_cmd        i_cmd,
    output t_st         o_st,
    output logic        o_result_strobe,
    output logic [11:0] o_position_echo,
    output logic [18:0] o_weight,
    output logic        o_out_of_range
);

    localparam int KW = $clog2(MAX_TERMS + 1);
    localparam logic [16:0] MAX_LEN17 = 17'(MAX_LENGTH);
    localparam logic [KW-1:0] K_END = KW'(MAX_TERMS);

    function automatic t_xn xn_add(input t_xn a, input t_xn b);
        t_xn big, sml, r;
        logic signed [16:0] d;
        logic [31:0] sm;
        logic [32:0] s;
        if (a.m == 32'd0) begin
            r = b;
        end else if (b.m == 32'd0) begin
            r = a;
        end else begin
            if (a.e >= b.e) begin
                big = a;
                sml = b;
            end else begin
                big = b;
                sml = a;
            end
            d  = 17'(big.e) - 17'(sml.e);
            sm = (d >= 17'sd63) ? 32'd0 : (sml.m >> d[5:0]);
            s  = {1'b0, big.m} + {1'b0, sm};
            if (s[32]) begin
                r.m = s[32:1];
                r.e = big.e + 16'sd1;
            end else begin
                r.m = s[31:0];
                r.e = big.e;
            end
        end
        return r;
    endfunction

    function automatic logic xn_lt(input t_xn a, input t_xn b);
        logic r;
        if (a.m == 32'd0)      r = (b.m != 32'd0);
        else if (b.m == 32'd0) r = 1'b0;
        else if (a.e != b.e)   r = (a.e < b.e);
        else                   r = (a.m < b.m);
        return r;
    endfunction

    function automatic t_xn beta_norm(input logic [15:0] b);
        t_xn r;
        logic [4:0] lz;
        logic found;
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 15; i >= 0; i--) begin
            if (!found) begin
                if (b[i]) found = 1'b1;
                else      lz = lz + 5'd1;
            end
        end
        r.m = {b, 16'd0} << lz;
        r.e = -16'sd28 - $signed({11'd0, lz});
        if (b == 16'd0) r = XN_ZERO;
        return r;
    endfunction

    // configuration
    logic [12:0] r_wl;
    logic [15:0] r_beta;

    // item
    logic [11:0] r_pos, r_m;
    logic [12:0] r_lm1;
    logic        r_oor, r_centre;
    logic [24:0] r_q;
    logic        r_qz;

    // working values
    t_xn r_numc, r_z, r_t, r_sum, r_term, r_tmp, r_num;
    logic [31:0]   r_qq;
    logic [KW-1:0] r_k;

    // unit sequencing
    t_op  r_op;
    logic r_run;
    logic r_done;

    logic [63:0]        r_prod;
    logic signed [16:0] r_pe;
    logic               r_pz;

    logic [63:0]        r_dvd;
    logic [31:0]        r_dvs, r_rem, r_quo;
    logic signed [15:0] r_de;
    logic [5:0]         r_cnt;

    logic [63:0] r_sv, r_sr;
    logic [4:0]  r_hsh;
    logic        r_sqit;

    logic        r_strobe, r_oflag;
    logic [11:0] r_echo;
    logic [18:0] r_weight;

    // accept-time geometry
    logic [12:0] len, pos13, rest, lm1;
    logic [11:0] m_acc;
    logic [24:0] q_prod;

    always_comb begin
        len   = ({4'd0, r_wl} > MAX_LEN17) ? MAX_LEN17[12:0] : r_wl;
        pos13 = {1'b0, i_position};
        lm1   = len - 13'd1;
        rest  = lm1 - pos13;
        m_acc = (pos13 < rest) ? i_position : rest[11:0];
        q_prod = 25'(r_m * (r_lm1 - {1'b0, r_m}));
    end

    // multiplier
    t_xn arg, mul_a, mul_b, mres;
    logic signed [16:0] me;

    always_comb begin
        arg = i_cmd.pass ? r_numc : r_z;
        case (i_cmd.op)
            OP_NUMC: begin mul_a = XN_PI;  mul_b = r_tmp; end
            OP_ZMUL: begin mul_a = r_numc; mul_b = r_tmp; end
            OP_SQ:   begin mul_a = arg;    mul_b = arg;   end
            OP_TMUL: begin mul_a = r_term; mul_b = r_tmp; end
            default: begin mul_a = XN_EPS; mul_b = r_sum; end
        endcase
        if (r_prod[63]) begin
            me     = r_pe + 17'sd32;
            mres.m = r_prod[63:32];
        end else begin
            me     = r_pe + 17'sd31;
            mres.m = r_prod[62:31];
        end
        mres.e = me[15:0];
        if (r_op == OP_SQ) mres.e = mres.e - 16'sd2;
        if (r_pz) mres = XN_ZERO;
    end

    // divider
    t_xn div_a;
    logic [31:0] div_d;
    logic [32:0] rem_sh;
    logic        q_bit;
    logic [31:0] d_rem, d_quo;
    logic        d_fin;
    t_xn         d_res;

    always_comb begin
        case (i_cmd.op)
            OP_ZDIV: begin div_a = r_tmp; div_d = {19'd0, r_lm1}; end
            OP_TDIV: begin div_a = r_t;   div_d = 32'(r_k) * 32'(r_k); end
            default: begin div_a = r_num; div_d = r_sum.m; end
        endcase
        rem_sh = {r_rem, r_dvd[r_cnt]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        d_rem  = q_bit ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
        d_quo  = {r_quo[30:0], q_bit};
        d_fin  = ((r_op != OP_QDIV) && d_quo[31]) || (r_cnt == 6'd0);
        d_res.m = d_quo;
        d_res.e = r_de + $signed({10'd0, r_cnt}) - 16'sd24;
    end

    // square root
    logic [63:0] sq_bit, sq_s, sq_v, sq_r;
    t_xn         root_x;

    always_comb begin
        sq_bit = 64'd1 << {r_cnt[4:0], 1'b0};
        sq_s   = r_sr + sq_bit;
        if (r_sv >= sq_s) begin
            sq_v = r_sv - sq_s;
            sq_r = (r_sr >> 1) + sq_bit;
        end else begin
            sq_v = r_sv;
            sq_r = r_sr >> 1;
        end
        if (sq_r[31]) begin
            root_x.m = sq_r[31:0];
            root_x.e = 16'sd1 - $signed({11'd0, r_hsh});
        end else begin
            root_x.m = {sq_r[30:0], 1'b0};
            root_x.e = -$signed({11'd0, r_hsh});
        end
    end

    // final rounding
    logic signed [17:0] fin_sh, fin_rn;
    logic [40:0]        w41;
    logic [18:0]        fin_w;

    always_comb begin
        fin_sh = 18'(r_num.e) - 18'(r_sum.e) - 18'sd13;
        fin_rn = -fin_sh;
        w41    = ({9'd0, r_qq} + (41'd1 << (fin_rn[5:0] - 6'd1))) >> fin_rn[5:0];
        if (r_oor)                   fin_w = 19'd0;
        else if (r_centre)           fin_w = ONE_Q18;
        else if (fin_sh >= 18'sd0)   fin_w = ONE_Q18;   // ratio at least one
        else if (fin_rn > 18'sd40)   fin_w = 19'd0;
        else if (w41 > 41'(ONE_Q18)) fin_w = ONE_Q18;
        else                         fin_w = w41[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl     <= 13'd1025;
            r_beta   <= 16'd20480;
            r_run    <= 1'b0;
            r_done   <= 1'b0;
            r_strobe <= 1'b0;
            r_op     <= OP_NONE;
        end else begin
            r_done   <= 1'b0;
            r_strobe <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LENGTH: r_wl   <= i_cfg_data[12:0];
                    CFG_BETA:   r_beta <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_pos    <= i_position;
                r_oor    <= (pos13 >= len);
                r_lm1    <= lm1;
                r_m      <= m_acc;
                r_centre <= ({m_acc, 1'b0} == lm1);
            end
            if (i_cmd.go) begin
                case (i_cmd.op)
                    OP_INIT: begin
                        r_tmp  <= beta_norm(r_beta);
                        r_q    <= q_prod;
                        r_qz   <= (q_prod == 25'd0);
                        r_done <= 1'b1;
                    end
                    OP_NUMC, OP_ZMUL, OP_SQ, OP_TMUL, OP_EMUL: begin
                        r_prod <= 64'(mul_a.m * mul_b.m);
                        r_pe   <= 17'(mul_a.e) + 17'(mul_b.e);
                        r_pz   <= (mul_a.m == 32'd0) || (mul_b.m == 32'd0);
                        r_op   <= i_cmd.op;
                        r_run  <= 1'b1;
                        if (i_cmd.op == OP_TMUL) r_k <= r_k + KW'(1);
                    end
                    OP_SQRT: begin
                        if (r_qz) begin
                            r_z    <= XN_ZERO;
                            r_done <= 1'b1;
                        end else begin
                            r_sv   <= {39'd0, r_q};
                            r_hsh  <= 5'd0;
                            r_sqit <= 1'b0;
                            r_op   <= OP_SQRT;
                            r_run  <= 1'b1;
                        end
                    end
                    OP_ZDIV, OP_TDIV, OP_QDIV: begin
                        if (div_a.m == 32'd0) begin
                            r_tmp  <= XN_ZERO;
                            r_done <= 1'b1;
                        end else begin
                            r_dvd <= (i_cmd.op == OP_QDIV) ? {1'b0, div_a.m, 31'd0}
                                                           : {8'd0, div_a.m, 24'd0};
                            r_dvs <= div_d;
                            r_de  <= div_a.e;
                            r_rem <= 32'd0;
                            r_quo <= 32'd0;
                            r_cnt <= 6'd63;
                            r_op  <= i_cmd.op;
                            r_run <= 1'b1;
                        end
                    end
                    OP_BINIT: begin
                        r_sum  <= xn_add(XN_ONE, r_t);
                        r_term <= r_t;
                        r_k    <= KW'(2);
                        r_done <= 1'b1;
                    end
                    OP_SADD: begin
                        r_sum  <= xn_add(r_sum, r_term);
                        r_done <= 1'b1;
                    end
                    OP_SAVE: begin
                        r_num  <= r_sum;
                        r_done <= 1'b1;
                    end
                    OP_FIN: begin
                        r_echo   <= r_pos;
                        r_oflag  <= r_oor;
                        r_weight <= fin_w;
                        r_strobe <= 1'b1;
                        r_done   <= 1'b1;
                    end
                    default: ;
                endcase
            end else if (r_run) begin
                case (r_op)
                    OP_NUMC, OP_ZMUL, OP_SQ, OP_TMUL, OP_EMUL: begin
                        case (r_op)
                            OP_NUMC: r_numc <= mres;
                            OP_ZMUL: r_z    <= mres;
                            OP_SQ:   r_t    <= mres;
                            OP_TMUL: r_term <= mres;
                            default: r_tmp  <= mres;
                        endcase
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                    OP_SQRT: begin
                        if (!r_sqit) begin
                            // even pre-shift up to the top of the word
                            if (r_sv[63:60] == 4'd0) begin
                                r_sv  <= r_sv << 2;
                                r_hsh <= r_hsh + 5'd1;
                            end else begin
                                r_sqit <= 1'b1;
                                r_cnt  <= 6'd31;
                                r_sr   <= 64'd0;
                            end
                        end else begin
                            r_sv <= sq_v;
                            r_sr <= sq_r;
                            r_cnt <= r_cnt - 6'd1;
                            if (r_cnt == 6'd0) begin
                                r_tmp  <= root_x;
                                r_run  <= 1'b0;
                                r_done <= 1'b1;
                            end
                        end
                    end
                    OP_ZDIV, OP_TDIV, OP_QDIV: begin
                        r_rem <= d_rem;
                        r_quo <= d_quo;
                        r_cnt <= r_cnt - 6'd1;
                        if (d_fin) begin
                            if (r_op == OP_QDIV) r_qq  <= d_quo;
                            else                 r_tmp <= d_res;
                            r_run  <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: r_run <= 1'b0;
                endcase
            end
        end
    end

    always_comb begin
        o_st.done   = r_done;
        o_st.oor    = r_oor;
        o_st.centre = r_centre;
        o_st.q_zero = r_qz;
        o_st.lt     = xn_lt(r_term, r_tmp);
        o_st.k_last = (r_k == K_END);
    end

    assign o_result_strobe = r_strobe;
    assign o_position_echo = r_echo;
    assign o_weight        = r_weight;
    assign o_out_of_range  = r_oflag;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe longer than one cycle");

    a_weight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_weight <= ONE_Q18))
        else $error("weight above one");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_oflag) |-> (r_weight == 19'd0))
        else $error("out-of-range word with non-zero weight");

endmodule

// ===== src/kwg_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwg_ctrl
// Sequencer: steps the datapath through the argument set-up, the two
// Bessel series and the final ratio for one word.
// ----------------------------------------------------------------------------
module kwg_ctrl import kwg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_st  i_st,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_INIT, S_NUMC, S_SQRT, S_ZDIV, S_ZMUL, S_SQ, S_BINIT,
        S_TDIV, S_TMUL, S_SADD, S_EMUL, S_TEST, S_SAVE, S_QDIV, S_FIN
    } t_state;

    t_state r_state;
    logic   r_wait;
    logic   r_pass;
    t_op    op;
    logic   exec;

    always_comb begin
        exec = 1'b1;
        case (r_state)
            S_INIT:  op = OP_INIT;
            S_NUMC:  op = OP_NUMC;
            S_SQRT:  op = OP_SQRT;
            S_ZDIV:  op = OP_ZDIV;
            S_ZMUL:  op = OP_ZMUL;
            S_SQ:    op = OP_SQ;
            S_BINIT: op = OP_BINIT;
            S_TDIV:  op = OP_TDIV;
            S_TMUL:  op = OP_TMUL;
            S_SADD:  op = OP_SADD;
            S_EMUL:  op = OP_EMUL;
            S_SAVE:  op = OP_SAVE;
            S_QDIV:  op = OP_QDIV;
            S_FIN:   op = OP_FIN;
            default: begin
                op   = OP_NONE;
                exec = 1'b0;
            end
        endcase
        o_cmd.load = i_start && (r_state == S_IDLE);
        o_cmd.go   = exec && !r_wait;
        o_cmd.op   = op;
        o_cmd.pass = r_pass;
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            if (exec && !r_wait) r_wait <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHK;
                        r_pass  <= 1'b0;
                    end
                end
                S_CHK: r_state <= (i_st.oor || i_st.centre) ? S_FIN : S_INIT;
                S_TEST: begin
                    if (i_st.lt || i_st.k_last) r_state <= r_pass ? S_QDIV : S_SAVE;
                    else                        r_state <= S_TDIV;
                end
                default: begin
                    if (r_wait && i_st.done) begin
                        r_wait <= 1'b0;
                        case (r_state)
                            S_INIT:  r_state <= S_NUMC;
                            S_NUMC:  r_state <= S_SQRT;
                            S_SQRT:  r_state <= i_st.q_zero ? S_SQ : S_ZDIV;
                            S_ZDIV:  r_state <= S_ZMUL;
                            S_ZMUL:  r_state <= S_SQ;
                            S_SQ:    r_state <= S_BINIT;
                            S_BINIT: r_state <= S_TDIV;
                            S_TDIV:  r_state <= S_TMUL;
                            S_TMUL:  r_state <= S_SADD;
                            S_SADD:  r_state <= S_EMUL;
                            S_EMUL:  r_state <= S_TEST;
                            S_SAVE: begin
                                r_pass  <= 1'b1;
                                r_state <= S_SQ;
                            end
                            S_QDIV:  r_state <= S_FIN;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> $past(i_st.done))
        else $error("sequencer left a word without a finished step");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the Kaiser window generator word by word against a bit-exact
// software model of its internal float format, across many length and
// beta settings, with random gaps on the command side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kwg_pkg::*;

    localparam int          WIN_MAX   = 4096;
    localparam int          SER_TERMS = 40;
    localparam int unsigned Q18_ONE   = 262144;

    typedef struct {
        longint unsigned m;
        int              e;
    } xf_t;

    typedef struct {
        logic [11:0] pos;
        logic [18:0] weight;
        logic        oor;
    } weight_word_t;

    class weight_scoreboard;
        weight_word_t    expected_q[$];
        logic [12:0]     length_reg = 13'd1025;
        logic [15:0]     beta_reg   = 16'd20480;
        int              fails      = 0;
        int              n_checked  = 0;

        function xf_t fnorm(longint unsigned m, int e);
            xf_t r;
            if (m == 0) begin
                r.m = 0;
                r.e = 0;
                return r;
            end
            while (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                e++;
            end
            while (m < 64'h8000_0000) begin
                m = m << 1;
                e--;
            end
            r.m = m;
            r.e = e;
            return r;
        endfunction

        function xf_t fmul(xf_t a, xf_t b);
            if (a.m == 0 || b.m == 0) return fnorm(0, 0);
            return fnorm(a.m * b.m, a.e + b.e);
        endfunction

        function xf_t fadd(xf_t a, xf_t b);
            xf_t             big_op, sml_op;
            int              d;
            longint unsigned sm;
            if (a.m == 0) return b;
            if (b.m == 0) return a;
            if (a.e >= b.e) begin
                big_op = a;
                sml_op = b;
            end else begin
                big_op = b;
                sml_op = a;
            end
            d  = big_op.e - sml_op.e;
            sm = (d >= 63) ? 64'd0 : (sml_op.m >> d);
            return fnorm(big_op.m + sm, big_op.e);
        endfunction

        function xf_t fdivi(xf_t a, longint unsigned d);
            if (a.m == 0 || d == 0) return a;
            return fnorm((a.m << 24) / d, a.e - 24);
        endfunction

        function bit flt(xf_t a, xf_t b);
            if (a.m == 0) return b.m != 0;
            if (b.m == 0) return 1'b0;
            if (a.e != b.e) return a.e < b.e;
            return a.m < b.m;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function xf_t bessel_i0(xf_t z);
            xf_t eps, t, sum, term;
            eps = fnorm(64'd2361183241, -71);
            t   = fmul(z, z);
            if (t.m != 0) t.e -= 2;
            sum  = fadd(fnorm(1, 0), t);
            term = t;
            for (int k = 2; k < SER_TERMS; k++) begin
                term = fmul(term, fdivi(t, longint'(k) * k));
                sum  = fadd(sum, term);
                if (flt(term, fmul(eps, sum))) break;
            end
            return sum;
        endfunction

        function weight_word_t kaiser_weight(logic [11:0] pos);
            weight_word_t    w;
            longint unsigned n, len, mm, q, root, qq, r;
            int              sh;
            xf_t             numc, z, num, den;
            n   = pos;
            len = length_reg;
            if (len > WIN_MAX) len = WIN_MAX;
            w.pos    = pos;
            w.weight = '0;
            w.oor    = 1'b0;
            if (n >= len) begin
                w.oor = 1'b1;
                return w;
            end
            mm = (n < len - 1 - n) ? n : (len - 1 - n);
            if (2 * mm == len - 1) begin
                w.weight = ONE_Q18;
                return w;
            end
            numc = fmul(fnorm(64'd3373259426, -30), fnorm(beta_reg, -12));
            q = mm * (len - 1 - mm);
            if (q == 0) begin
                z = fnorm(0, 0);
            end else begin
                sh = 0;
                while (q < (64'd1 << 60)) begin
                    q = q << 2;
                    sh += 2;
                end
                root = int_root(q);
                z = fdivi(fnorm(root, 1 - sh / 2), len - 1);
                z = fmul(numc, z);
            end
            num = bessel_i0(z);
            den = bessel_i0(numc);
            qq  = (num.m << 31) / den.m;
            sh  = num.e - den.e - 31 + 18;
            if (sh >= 0) begin
                if (sh >= 32 || (qq << sh) > Q18_ONE) r = Q18_ONE;
                else r = qq << sh;
            end else begin
                if (-sh > 40) r = 0;
                else r = (qq + (64'd1 << (-sh - 1))) >> (-sh);
                if (r > Q18_ONE) r = Q18_ONE;
            end
            w.weight = r[18:0];
            return w;
        endfunction

        function void note_position(logic [11:0] pos);
            expected_q.push_back(kaiser_weight(pos));
        endfunction

        function void check_word(logic [11:0] pos, logic [18:0] weight, logic oor);
            weight_word_t x;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word pos=%0d weight=%0d oor=%0b",
                         $time, pos, weight, oor);
                fails++;
                return;
            end
            x = expected_q.pop_front();
            n_checked++;
            if (x.pos !== pos) begin
                $display("%0t: position_echo expected %0d actual %0d", $time, x.pos, pos);
                fails++;
            end
            if (x.weight !== weight) begin
                $display("%0t: weight (pos %0d, M=%0d, beta=%0d) expected %0d actual %0d",
                         $time, x.pos, length_reg, beta_reg, x.weight, weight);
                fails++;
            end
            if (x.oor !== oor) begin
                $display("%0t: out_of_range expected %0b actual %0b", $time, x.oor, oor);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [11:0] i_position;
    logic        o_result_strobe;
    logic [11:0] o_position_echo;
    logic [18:0] o_weight;
    logic        o_out_of_range;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    weight_scoreboard sb = new();
    int               n_sent   = 0;
    int               n_phases = 0;

    kaiser_window_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_position      (i_position),
        .o_result_strobe (o_result_strobe),
        .o_position_echo (o_position_echo),
        .o_weight        (o_weight),
        .o_out_of_range  (o_out_of_range),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // both sides sampled at the same edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_position(i_position);
        if (i_rst_n && o_result_strobe)
            sb.check_word(o_position_echo, o_weight, o_out_of_range);
    end

    task automatic send_position(logic [11:0] pos, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_position <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0 || busy) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // valid stays high; the caller drops it after the last write
    task automatic write_reg(logic idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_LENGTH) sb.length_reg = data[12:0];
        else sb.beta_reg = data;
    endtask

    task automatic set_window(logic [15:0] len, logic [15:0] beta);
        wait_idle();
        write_reg(CFG_LENGTH, len);
        write_reg(CFG_BETA, beta);
        i_cfg_valid <= 1'b0;
        n_phases++;
    endtask

    initial begin
        int          len_eff, gap;
        bit          burst;
        logic [15:0] len_w, beta_w;
        logic [11:0] pos;
        start       <= 1'b0;
        i_position  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_LENGTH;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: edges, centre, just past the end
        send_position(12'd0, 0);
        send_position(12'd512, 1);
        send_position(12'd1024, 0);
        send_position(12'd1025, 2);
        send_position(12'd4095, 0);
        // length one gives unity, length zero rejects all
        set_window(16'd1, 16'd20480);
        send_position(12'd0, 0);
        send_position(12'd1, 0);
        set_window(16'd0, 16'd4096);
        send_position(12'd0, 0);
        // beta zero, shortest real window
        set_window(16'd2, 16'd0);
        send_position(12'd0, 0);
        send_position(12'd1, 0);
        // longest window at the top of the beta range
        set_window(16'd4096, 16'd57344);
        send_position(12'd0, 0);
        send_position(12'd2047, 3);
        send_position(12'd2048, 0);
        send_position(12'd4095, 0);
        // oversize length clamps, beta beyond 14.0 unclamped
        set_window(16'hFFFF, 16'hFFFF);
        send_position(12'd4095, 0);
        send_position(12'd100, 0);
        send_position(12'd2048, 0);
        set_window(16'd4097, 16'd1);
        send_position(12'd1, 0);
        send_position(12'd4094, 0);

        while (n_sent < 2000) begin
            case ($urandom_range(0, 3))
                0:       len_w = 16'($urandom_range(2, 64));
                1:       len_w = 16'($urandom_range(0, 4096));
                2:       len_w = 16'($urandom_range(0, 65535));
                default: len_w = 16'($urandom_range(3, 300));
            endcase
            case ($urandom_range(0, 3))
                0:       beta_w = 16'($urandom_range(0, 65535));
                1:       beta_w = 16'($urandom_range(0, 8192));
                default: beta_w = 16'($urandom_range(0, 57344));
            endcase
            set_window(len_w, beta_w);
            len_eff = (len_w[12:0] > WIN_MAX) ? WIN_MAX : len_w[12:0];
            burst   = $urandom_range(0, 3) == 0;
            repeat (100) begin
                if ($urandom_range(0, 7) == 0 || len_eff == 0)
                    pos = 12'($urandom_range(0, 4095));
                else
                    pos = 12'($urandom_range(0, len_eff - 1));
                gap = burst ? 0 : $urandom_range(0, 8);
                send_position(pos, gap);
            end
        end

        wait_idle();
        $display("covered %0d positions over %0d length/beta settings, %0d words checked",
                 n_sent, n_phases, sb.n_checked);
        if (sb.fails == 0 && sb.expected_q.size() == 0) begin
            $display("kaiser_window_generator: match");
        end else begin
            $display("kaiser_window_generator: mismatch");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("timeout after %0d positions", n_sent);
        $display("kaiser_window_generator: mismatch");
        $finish;
    end

endmodule
